/* rtl/bmp_pkg.sv */
// shared types and constants for the binomial-mod-prime block
// no dependencies
`default_nettype none

package bmp_pkg;

    localparam int unsigned W         = 31;
    localparam int unsigned MAX_TERMS = 256;
    localparam int unsigned I_W       = $clog2(MAX_TERMS + 1);
    localparam int unsigned CNT_W     = $clog2(W);

    localparam logic [W-1:0] PRIME_RESET = W'(1000000007);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_CHECK    = 11'b000_0000_0010,
        ST_TERM     = 11'b000_0000_0100,
        ST_WAIT_N   = 11'b000_0000_1000,
        ST_WAIT_B   = 11'b000_0001_0000,
        ST_POW      = 11'b000_0010_0000,
        ST_WAIT_R   = 11'b000_0100_0000,
        ST_WAIT_SQ  = 11'b000_1000_0000,
        ST_WAIT_INV = 11'b001_0000_0000,
        ST_DONE     = 11'b010_0000_0000,
        ST_INV      = 11'b100_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_ACC_N   = 3'd0,
        OP_BASE    = 3'd1,
        OP_R       = 3'd2,
        OP_SQ      = 3'd3,
        OP_ACC_INV = 3'd4
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        op_t  op;
        logic pow_init;
        logic clear_r;
        logic e_shift;
        logic next_term;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic over;
        logic p_small;
        logic terms_done;
        logic base_zero;
        logic e_zero;
        logic e_bit;
        logic mul_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/bmp_mulmod.sv */
// shift-and-add modular multiplier, one multiplier bit per cycle
// depends on bmp_pkg
`default_nettype none

module bmp_mulmod
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire [bmp_pkg::W-1:0]  a,
    input  wire [bmp_pkg::W-1:0]  b,
    input  wire [bmp_pkg::W-1:0]  p,
    output logic                  done,
    output logic [bmp_pkg::W-1:0] result
);
    import bmp_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     r_reg, r_next;
    logic [W:0]       dbl, dbl_red, sum, sum_red;

    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        sum     = dbl_red + (b_reg[W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
        result  = sum_red[W-1:0];
        done    = busy_reg && (cnt_reg == '0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            a_next    = a;
            b_next    = b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = result;
            b_next = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

endmodule

`default_nettype wire

/* rtl/bmp_datapath.sv */
// operand registers, term counter, exponent and output register
// depends on bmp_pkg and bmp_mulmod
`default_nettype none

module bmp_datapath
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  bmp_pkg::cmd_t         cmd,
    output bmp_pkg::status_t      status,
    input  wire [bmp_pkg::W-1:0]  p,
    input  wire [bmp_pkg::W-1:0]  total_count,
    input  wire [bmp_pkg::W-1:0]  pick_count,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [bmp_pkg::W-1:0] residue,
    output logic                  too_many_terms
);
    import bmp_pkg::*;

    logic [W-1:0]   n_reg, t_reg, acc_reg, base_reg, r_reg, e_reg;
    logic           bad_reg;
    logic [I_W-1:0] i_reg;
    op_t            op_reg;
    logic           ov_reg, ov_next;
    logic [W-1:0]   res_reg;
    logic           tmt_reg;
    logic [W-1:0]   diff, ma, mb, prod;
    logic           mdone;

    assign diff = total_count - pick_count;

    always_comb
    begin
        ma = acc_reg;
        mb = n_reg - W'(i_reg);
        case (cmd.op)
            OP_ACC_N:
            begin
                ma = acc_reg;
                mb = n_reg - W'(i_reg);
            end
            OP_BASE:
            begin
                ma = W'(1);
                mb = W'(i_reg) + W'(1);
            end
            OP_R:
            begin
                ma = r_reg;
                mb = base_reg;
            end
            OP_SQ:
            begin
                ma = base_reg;
                mb = base_reg;
            end
            OP_ACC_INV:
            begin
                ma = acc_reg;
                mb = r_reg;
            end
            default:
            begin
                ma = acc_reg;
                mb = r_reg;
            end
        endcase
    end

    bmp_mulmod u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (ma),
        .b      (mb),
        .p      (p),
        .done   (mdone),
        .result (prod)
    );

    always_comb
    begin
        status.bad        = bad_reg;
        status.over       = !bad_reg && (t_reg > W'(MAX_TERMS));
        status.p_small    = p < W'(2);
        status.terms_done = i_reg == t_reg[I_W-1:0];
        status.base_zero  = base_reg == '0;
        status.e_zero     = e_reg == '0;
        status.e_bit      = e_reg[0];
        status.mul_done   = mdone;
        status.out_free   = !ov_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= total_count;
            bad_reg <= pick_count > total_count;
            t_reg   <= (pick_count < diff) ? pick_count : diff;
            i_reg   <= '0;
            acc_reg <= W'(1);
        end
        if (cmd.next_term)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.pow_init)
        begin
            r_reg <= W'(1);
            e_reg <= p - W'(2);
        end
        if (cmd.clear_r)
        begin
            r_reg <= '0;
        end
        if (cmd.e_shift)
        begin
            e_reg <= e_reg >> 1;
        end
        if (mdone)
        begin
            case (op_reg)
                OP_ACC_N:   acc_reg  <= prod;
                OP_BASE:    base_reg <= prod;
                OP_R:       r_reg    <= prod;
                OP_SQ:      base_reg <= prod;
                OP_ACC_INV: acc_reg  <= prod;
                default:    acc_reg  <= prod;
            endcase
        end
        if (cmd.mul_start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.emit)
        begin
            tmt_reg <= status.over;
            res_reg <= (bad_reg || status.over || status.p_small) ? '0 : acc_reg;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (cmd.emit)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    assign out_valid      = ov_reg;
    assign residue        = res_reg;
    assign too_many_terms = tmt_reg;

endmodule

`default_nettype wire

/* rtl/bmp_ctrl.sv */
// controller state machine sequencing terms and the fermat inverse
// depends on bmp_pkg
`default_nettype none

module bmp_ctrl
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  bmp_pkg::status_t  status,
    output bmp_pkg::cmd_t     cmd
);
    import bmp_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_ACC_N;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.bad || status.over || status.p_small)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (status.terms_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.op        = OP_ACC_N;
                    state_next    = ST_WAIT_N;
                end
            end
            ST_WAIT_N:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.op        = OP_BASE;
                    state_next    = ST_WAIT_B;
                end
            end
            ST_WAIT_B:
            begin
                if (status.mul_done)
                begin
                    cmd.pow_init = 1'b1;
                    state_next   = ST_POW;
                end
            end
            ST_POW:
            begin
                if (status.base_zero)
                begin
                    cmd.clear_r = 1'b1;
                    state_next  = ST_INV;
                end
                else if (status.e_zero)
                begin
                    state_next = ST_INV;
                end
                else if (status.e_bit)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.op        = OP_R;
                    state_next    = ST_WAIT_R;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.op        = OP_SQ;
                    state_next    = ST_WAIT_SQ;
                end
            end
            ST_WAIT_R:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.op        = OP_SQ;
                    state_next    = ST_WAIT_SQ;
                end
            end
            ST_WAIT_SQ:
            begin
                if (status.mul_done)
                begin
                    cmd.e_shift = 1'b1;
                    state_next  = ST_POW;
                end
            end
            ST_INV:
            begin
                cmd.mul_start = 1'b1;
                cmd.op        = OP_ACC_INV;
                state_next    = ST_WAIT_INV;
            end
            ST_WAIT_INV:
            begin
                if (status.mul_done)
                begin
                    cmd.next_term = 1'b1;
                    state_next    = ST_TERM;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/binomial_mod_prime.sv */
// top level: prime register, controller and datapath
// depends on bmp_pkg, bmp_ctrl and bmp_datapath
`default_nettype none

// Returns C(n,k) mod p for one (total_count, pick_count) transfer at a time, with p taken
// from a register written through cfg_wr_en/cfg_wr_data (reset value 1000000007). k > n,
// a modulus below two, or min(k,n-k) above 256 (too_many_terms set) give residue 0. All
// products go through one shift-and-add modular multiplier; a term needs one product each
// for (n-i) and (i+1), one per bit and one per set bit of (p-2) for the Fermat inverse,
// and one to scale the accumulator. A finished result sits in an output register, so the
// next input can be taken while it waits.
module binomial_mod_prime
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire [bmp_pkg::W-1:0]  cfg_wr_data,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire [bmp_pkg::W-1:0]  total_count,
    input  wire [bmp_pkg::W-1:0]  pick_count,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [bmp_pkg::W-1:0] residue,
    output logic                  too_many_terms
);
    import bmp_pkg::*;

    logic [W-1:0] prime_reg;
    cmd_t         cmd;
    status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= PRIME_RESET;
        end
        else if (cfg_wr_en)
        begin
            prime_reg <= cfg_wr_data;
        end
    end

    bmp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bmp_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .p              (prime_reg),
        .total_count    (total_count),
        .pick_count     (pick_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .residue        (residue),
        .too_many_terms (too_many_terms)
    );

endmodule

`default_nettype wire
